>>> rtl/fths_pkg.sv
package fths_pkg;

  localparam logic [1:0] RegTrackingEnable = 2'd0;
  localparam logic [1:0] RegLostLimit      = 2'd1;
  localparam logic [1:0] RegNeckStep       = 2'd2;

  localparam logic [9:0]  CentreCol = 10'd320;
  localparam logic [8:0]  CentreRow = 9'd240;
  localparam logic [17:0] RecipFive = 18'd205;

  localparam logic signed [9:0] EyeLow   = 10'sd70;
  localparam logic signed [9:0] EyeHigh  = 10'sd170;
  localparam logic signed [9:0] IrisLow  = 10'sd65;
  localparam logic signed [9:0] IrisHigh = 10'sd175;

  localparam logic [8:0] PitchLow  = 9'd74;
  localparam logic [8:0] PitchHigh = 9'd140;
  localparam logic [8:0] YawLow    = 9'd87;
  localparam logic [8:0] YawHigh   = 9'd153;
  localparam logic [7:0] HomePitch = 8'd110;
  localparam logic [7:0] HomeYaw   = 8'd120;
  localparam logic [7:0] ResetHead = 8'd120;

  localparam logic [9:0] NeckLeftBase  = 10'd360;
  localparam logic [9:0] NeckRightBase = 10'd120;

  typedef struct packed {
    logic              face_found;
    logic [9:0]        face_col;
    logic [8:0]        face_row;
    logic signed [3:0] iris_jitter;
  } in_item_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [7:0] eye_pitch_cmd;
    logic [7:0] eye_yaw_cmd;
    logic [7:0] iris_cmd;
    logic [7:0] neck_left_cmd;
    logic [7:0] neck_right_cmd;
  } out_item_t;

  typedef struct packed {
    logic       tracking_enable;
    logic [7:0] lost_limit;
    logic [3:0] neck_step;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic              x_pos;
    logic [7:0]        x_quot;
    logic              y_pos;
    logic [7:0]        y_quot;
    logic signed [3:0] jitter;
  } offset_t;

  function automatic logic [7:0] clamp_head(logic [8:0] v, logic [8:0] lo, logic [8:0] hi);
    logic [8:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r[7:0];
  endfunction

endpackage

>>> rtl/fths_apb_regs.sv
module fths_apb_regs import fths_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        RegTrackingEnable: cfg_d.tracking_enable = pwdata[0];
        RegLostLimit:      cfg_d.lost_limit      = pwdata[7:0];
        RegNeckStep:       cfg_d.neck_step       = pwdata[3:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegTrackingEnable: prdata = {31'd0, cfg_q.tracking_enable};
      RegLostLimit:      prdata = {24'd0, cfg_q.lost_limit};
      RegNeckStep:       prdata = {28'd0, cfg_q.neck_step};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tracking_enable <= 1'b0;
      cfg_q.lost_limit      <= 8'd30;
      cfg_q.neck_step       <= 4'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/fths_offset_stage.sv
module fths_offset_stage import fths_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_stall_o,
  input  logic     advance_i,
  output logic     off_valid_o,
  output offset_t  off_o
);

  // The division by five is a multiplication by 205/1024, exact for magnitudes below 1024.
  logic signed [10:0] sx, sy;
  logic [9:0]         x_mag, y_mag;
  logic [17:0]        x_prod, y_prod;
  logic               load;
  logic               valid_q, valid_d;
  offset_t            off_q, off_d;

  always_comb begin
    sx     = $signed({1'b0, CentreCol}) - $signed({1'b0, in_data_i.face_col});
    sy     = $signed({2'b00, in_data_i.face_row}) - $signed({2'b00, CentreRow});
    x_mag  = (sx > 11'sd0) ? sx[9:0] : 10'(-sx);
    y_mag  = (sy > 11'sd0) ? sy[9:0] : 10'(-sy);
    x_prod = {8'd0, x_mag} * RecipFive;
    y_prod = {8'd0, y_mag} * RecipFive;
    off_d.found  = in_data_i.face_found;
    off_d.x_pos  = sx > 11'sd0;
    off_d.x_quot = x_prod[17:10];
    off_d.y_pos  = sy > 11'sd0;
    off_d.y_quot = y_prod[17:10];
    off_d.jitter = in_data_i.iris_jitter;
  end

  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      off_q <= off_d;
    end
  end

  assign off_valid_o = valid_q;
  assign off_o       = off_q;

endmodule

>>> rtl/fths_track_core.sv
module fths_track_core import fths_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      off_valid_i,
  input  offset_t   off_i,
  output logic      advance_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  logic [7:0] eye_pitch_q, eye_pitch_d, eye_yaw_q, eye_yaw_d, iris_q, iris_d;
  logic [7:0] head_pitch_q, head_pitch_d, head_yaw_q, head_yaw_d;
  logic [7:0] lost_q, lost_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic       take;

  logic signed [9:0] yaw_v, pitch_v, iris_v;
  logic [8:0]        hy_up, hy_dn, hp_up, hp_dn, lost_next;
  logic [9:0]        left_v, right_v;

  assign advance_o   = ~out_valid_q | ~out_stall_i;
  assign take        = off_valid_i & advance_o;
  assign out_valid_d = take | (out_valid_q & out_stall_i);

  always_comb begin
    eye_pitch_d  = eye_pitch_q;
    eye_yaw_d    = eye_yaw_q;
    iris_d       = iris_q;
    head_pitch_d = head_pitch_q;
    head_yaw_d   = head_yaw_q;
    lost_d       = lost_q;

    hy_up     = {1'b0, head_yaw_q} + {5'd0, cfg_i.neck_step};
    hy_dn     = {1'b0, head_yaw_q} - {5'd0, cfg_i.neck_step};
    hp_up     = {1'b0, head_pitch_q} + {5'd0, cfg_i.neck_step};
    hp_dn     = {1'b0, head_pitch_q} - {5'd0, cfg_i.neck_step};
    lost_next = {1'b0, lost_q} + 9'd1;

    iris_v = $signed({2'b00, iris_q}) + 10'(off_i.jitter);
    if (off_i.x_pos) begin
      yaw_v = $signed({2'b00, eye_yaw_q}) - $signed({2'b00, off_i.x_quot});
    end else begin
      yaw_v = $signed({2'b00, eye_yaw_q}) + $signed({2'b00, off_i.x_quot});
    end
    if (off_i.y_pos) begin
      pitch_v = $signed({2'b00, eye_pitch_q}) + $signed({2'b00, off_i.y_quot});
    end else begin
      pitch_v = $signed({2'b00, eye_pitch_q}) - $signed({2'b00, off_i.y_quot});
    end

    if (cfg_i.tracking_enable) begin
      if (off_i.found) begin
        if (iris_v < IrisLow) begin
          iris_d = IrisLow[7:0];
        end else if (iris_v > IrisHigh) begin
          iris_d = IrisHigh[7:0];
        end else begin
          iris_d = iris_v[7:0];
        end

        eye_yaw_d = yaw_v[7:0];
        if (off_i.x_pos && yaw_v < EyeLow) begin
          eye_yaw_d  = EyeLow[7:0];
          head_yaw_d = clamp_head(hy_dn, YawLow, YawHigh);
        end else if (!off_i.x_pos && yaw_v > EyeHigh) begin
          eye_yaw_d  = EyeHigh[7:0];
          head_yaw_d = clamp_head(hy_up, YawLow, YawHigh);
        end

        eye_pitch_d = pitch_v[7:0];
        if (off_i.y_pos && pitch_v > EyeHigh) begin
          eye_pitch_d  = EyeHigh[7:0];
          head_pitch_d = clamp_head(hp_up, PitchLow, PitchHigh);
        end else if (!off_i.y_pos && pitch_v < EyeLow) begin
          eye_pitch_d  = EyeLow[7:0];
          head_pitch_d = clamp_head(hp_dn, PitchLow, PitchHigh);
        end

        lost_d = 8'd0;
      end else if (lost_next > {1'b0, cfg_i.lost_limit}) begin
        head_pitch_d = HomePitch;
        head_yaw_d   = HomeYaw;
        lost_d       = 8'd0;
      end else begin
        lost_d = lost_next[7:0];
      end
    end

    left_v  = NeckLeftBase - {2'b00, head_pitch_d} - {2'b00, head_yaw_d};
    right_v = NeckRightBase - {2'b00, head_pitch_d} + {2'b00, head_yaw_d};

    out_d.cmd_valid      = cfg_i.tracking_enable;
    out_d.eye_pitch_cmd  = eye_pitch_d;
    out_d.eye_yaw_cmd    = eye_yaw_d;
    out_d.iris_cmd       = iris_d;
    out_d.neck_left_cmd  = left_v[7:0];
    out_d.neck_right_cmd = right_v[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      eye_pitch_q  <= 8'd0;
      eye_yaw_q    <= 8'd0;
      iris_q       <= 8'd0;
      head_pitch_q <= ResetHead;
      head_yaw_q   <= ResetHead;
      lost_q       <= 8'd0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        eye_pitch_q  <= eye_pitch_d;
        eye_yaw_q    <= eye_yaw_d;
        iris_q       <= iris_d;
        head_pitch_q <= head_pitch_d;
        head_yaw_q   <= head_yaw_d;
        lost_q       <= lost_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/face_tracking_head_servo_step.sv
// An accepted report is held in the input register, then in the result register.
// One report is accepted every cycle unless the output stalls; the input register
// and the result register let a new report enter while a finished result waits
// to be taken. The asynchronous active-low reset empties both stages, restores the
// register defaults and sets the head to its power-on pose.
module face_tracking_head_servo_step import fths_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  input  in_item_t    in_data_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output out_item_t   out_data_o,
  input  logic        out_stall_i
);

  cfg_t    cfg;
  logic    advance;
  logic    off_valid;
  offset_t off;

  fths_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fths_offset_stage u_offset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .advance_i   (advance),
    .off_valid_o (off_valid),
    .off_o       (off)
  );

  fths_track_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .off_valid_i (off_valid),
    .off_i       (off),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fths_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int CENTRE_X = 320;
  localparam int CENTRE_Y = 240;
  localparam int EYE_MIN = 70;
  localparam int EYE_MAX = 170;
  localparam int IRIS_MIN = 65;
  localparam int IRIS_MAX = 175;
  localparam int TILT_MIN = 74;
  localparam int TILT_MAX = 140;
  localparam int PAN_MIN = 87;
  localparam int PAN_MAX = 153;
  localparam int PARK_TILT = 110;
  localparam int PARK_PAN = 120;
  localparam int LEFT_BASE = 360;
  localparam int RIGHT_BASE = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  in_item_t    in_data_i = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_item_t   out_data_o;
  logic        out_stall_i = 1'b0;

  face_tracking_head_servo_step uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the configuration registers and of the head state.
  logic       track_en = 1'b0;
  logic [7:0] lost_lim = 8'd30;
  logic [3:0] neck_inc = 4'd3;
  logic [7:0] eye_tilt = 8'd0;
  logic [7:0] eye_pan = 8'd0;
  logic [7:0] iris_at = 8'd0;
  logic [7:0] head_tilt = 8'd120;
  logic [7:0] head_pan = 8'd120;
  logic [7:0] miss_cnt = 8'd0;

  in_item_t  report_q[$];
  out_item_t servo_cmds_due[$];
  out_item_t cmd_want;
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  int        in_gap = 0;
  int        out_hold = 0;

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the head state by one report and gives the servo commands that follow.
  function automatic out_item_t servo_commands(in_item_t rep);
    int x, y, pan_v, tilt_v, inc, nxt;
    out_item_t c;
    inc = int'(neck_inc);
    if (track_en) begin
      if (rep.face_found) begin
        x = CENTRE_X - int'(rep.face_col);
        y = int'(rep.face_row) - CENTRE_Y;
        iris_at = 8'(clip(int'(iris_at) + int'(rep.iris_jitter), IRIS_MIN, IRIS_MAX));
        pan_v = int'(eye_pan) - (x * 2) / 10;
        if (x > 0) begin
          if (pan_v < EYE_MIN) begin
            pan_v = EYE_MIN;
            head_pan = 8'(clip(int'(head_pan) - inc, PAN_MIN, PAN_MAX));
          end
        end else if (pan_v > EYE_MAX) begin
          pan_v = EYE_MAX;
          head_pan = 8'(clip(int'(head_pan) + inc, PAN_MIN, PAN_MAX));
        end
        tilt_v = int'(eye_tilt) + (y * 2) / 10;
        if (y > 0) begin
          if (tilt_v > EYE_MAX) begin
            tilt_v = EYE_MAX;
            head_tilt = 8'(clip(int'(head_tilt) + inc, TILT_MIN, TILT_MAX));
          end
        end else if (tilt_v < EYE_MIN) begin
          tilt_v = EYE_MIN;
          head_tilt = 8'(clip(int'(head_tilt) - inc, TILT_MIN, TILT_MAX));
        end
        eye_pan = 8'(pan_v);
        eye_tilt = 8'(tilt_v);
        miss_cnt = 8'd0;
      end else begin
        nxt = int'(miss_cnt) + 1;
        if (nxt > int'(lost_lim)) begin
          head_tilt = 8'(PARK_TILT);
          head_pan = 8'(PARK_PAN);
          miss_cnt = 8'd0;
        end else begin
          miss_cnt = 8'(nxt);
        end
      end
    end
    c.cmd_valid = track_en;
    c.eye_pitch_cmd = eye_tilt;
    c.eye_yaw_cmd = eye_pan;
    c.iris_cmd = iris_at;
    c.neck_left_cmd = 8'(LEFT_BASE - int'(head_tilt) - int'(head_pan));
    c.neck_right_cmd = 8'(RIGHT_BASE - int'(head_tilt) + int'(head_pan));
    return c;
  endfunction

  function automatic int draw_wait();
    if (cycle_cnt % 3000 < 800) return 0;
    return $urandom_range(0, 17);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (in_gap != 0) begin
        in_gap = in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (report_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= report_q.pop_front();
        in_gap = draw_wait();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        out_hold = draw_wait();
      end else if (out_hold != 0) begin
        out_hold = out_hold - 1;
      end
      out_stall_i <= (out_hold != 0);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) servo_cmds_due.push_back(servo_commands(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (servo_cmds_due.size() == 0) begin
          $display("%0t: result transfer expected none actual %h", $time, out_data_o);
          mismatch_cnt++;
        end else begin
          cmd_want = servo_cmds_due.pop_front();
          check_field("cmd_valid", 8'(cmd_want.cmd_valid), 8'(out_data_o.cmd_valid));
          check_field("eye_pitch_cmd", cmd_want.eye_pitch_cmd, out_data_o.eye_pitch_cmd);
          check_field("eye_yaw_cmd", cmd_want.eye_yaw_cmd, out_data_o.eye_yaw_cmd);
          check_field("iris_cmd", cmd_want.iris_cmd, out_data_o.iris_cmd);
          check_field("neck_left_cmd", cmd_want.neck_left_cmd, out_data_o.neck_left_cmd);
          check_field("neck_right_cmd", cmd_want.neck_right_cmd, out_data_o.neck_right_cmd);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic en, logic [7:0] lim, logic [3:0] inc);
    reg_write(RegTrackingEnable, 32'(en));
    reg_write(RegLostLimit, 32'(lim));
    reg_write(RegNeckStep, 32'(inc));
    track_en = en;
    lost_lim = lim;
    neck_inc = inc;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (report_q.size() != 0 || in_valid_i || servo_cmds_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic add_report(logic found, int col, int row, int jit);
    in_item_t r;
    r.face_found = found;
    r.face_col = 10'(col);
    r.face_row = 9'(row);
    r.iris_jitter = 4'(jit);
    report_q.push_back(r);
  endtask

  function automatic in_item_t rand_report();
    in_item_t r;
    r.face_found = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 5))
      0: r.face_col = 10'($urandom_range(640, 1023));
      1: r.face_col = 10'($urandom_range(310, 330));
      default: r.face_col = 10'($urandom_range(0, 639));
    endcase
    case ($urandom_range(0, 5))
      0: r.face_row = 9'($urandom_range(480, 511));
      1: r.face_row = 9'($urandom_range(230, 250));
      default: r.face_row = 9'($urandom_range(0, 479));
    endcase
    r.iris_jitter = 4'($urandom_range(0, 15));
    return r;
  endfunction

  task automatic queue_reports(int n);
    int k, run, side, sgn;
    in_item_t r;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          run = $urandom_range(1, int'(lost_lim) + 3);
          repeat (run) begin
            r = rand_report();
            r.face_found = 1'b0;
            report_q.push_back(r);
          end
          k += run;
        end
        2, 3, 4: begin
          side = $urandom_range(0, 3);
          sgn = $urandom_range(0, 1);
          run = $urandom_range(3, 25);
          repeat (run) begin
            r = rand_report();
            r.face_found = 1'b1;
            case (side)
              0: r.face_col = 10'($urandom_range(0, 200));
              1: r.face_col = 10'($urandom_range(440, 1023));
              2: r.face_row = 9'($urandom_range(0, 150));
              default: r.face_row = 9'($urandom_range(330, 511));
            endcase
            r.iris_jitter = 4'(sgn ? $urandom_range(8, 15) : $urandom_range(0, 7));
            report_q.push_back(r);
          end
          k += run;
        end
        9: begin
          report_q.push_back(in_item_t'($bits(in_item_t)'($urandom)));
          k++;
        end
        default: begin
          report_q.push_back(rand_report());
          k++;
        end
      endcase
    end
  endtask

  initial begin
    int ph;
    in_item_t r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_report(1'b1, 0, 0, 7);
    add_report(1'b0, 1023, 511, -8);
    wait_idle();
    set_config(1'b1, 8'd3, 4'd15);
    add_report(1'b0, 0, 0, 0);
    add_report(1'b1, 320, 240, 0);
    add_report(1'b1, 0, 0, -5);
    add_report(1'b1, 0, 0, -8);
    add_report(1'b1, 0, 0, -8);
    for (int i = 0; i < 8; i++) begin
      add_report(1'b1, (i % 2 == 0) ? 1023 : 639, (i % 2 == 0) ? 511 : 479, 7);
    end
    add_report(1'b1, 321, 241, 7);
    add_report(1'b1, 325, 235, -1);
    add_report(1'b1, 315, 245, 3);
    add_report(1'b0, 1023, 511, 7);
    add_report(1'b0, 0, 0, -8);
    add_report(1'b0, 512, 256, 0);
    add_report(1'b0, 511, 255, -1);
    add_report(1'b1, 320, 240, -8);

    for (ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        2: set_config(1'b0, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        3: set_config(1'b1, 8'd0, 4'd0);
        4: set_config(1'b1, 8'd255, 4'd15);
        default: set_config(1'b1, 8'($urandom_range(0, 40)), 4'($urandom_range(1, 15)));
      endcase
      if (ph == 4) begin
        repeat (257) begin
          r = rand_report();
          r.face_found = 1'b0;
          report_q.push_back(r);
        end
      end
      queue_reports((ph == 2) ? 60 : 130);
    end

    wait_idle();
    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
